[rtl/ptd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_pkg
// shared constants, transaction types, status codes and controller types
// for the periodic task timeline dispatcher
// ---------------------------------------------------------------------------
package ptd_pkg;

  // sizing
  localparam int TIMELINE_DEPTH = 32;
  localparam int MAX_TASKS      = 4;
  localparam int NUM_LEVELS     = 4;
  localparam int US_PER_MS      = 1000;
  localparam int PERIOD_MAX     = 1023;
  localparam int PRIO_MAX       = 3;
  localparam int SPACING_RESET  = 200;

  // field widths
  localparam int PERIOD_W  = 10;
  localparam int PRIO_W    = 3;
  localparam int LVL_W     = 2;
  localparam int SLOT_W    = 2;
  localparam int DELAY_W   = 20;
  localparam int SPACING_W = 8;

  // derived widths
  localparam int IDX_W      = $clog2(TIMELINE_DEPTH);
  localparam int CNT_W      = $clog2(TIMELINE_DEPTH + 1);
  localparam int TASK_CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TIDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  // any span above this cannot fit the timeline, so the span saturates one above it
  localparam int SPAN_LIMIT = TIMELINE_DEPTH * PERIOD_MAX;
  localparam int SPAN_W     = $clog2(2 * SPAN_LIMIT + 3);
  localparam int TIME_W     = $clog2((SPAN_LIMIT + 1 + PERIOD_MAX) * US_PER_MS + 1);
  localparam int ENTRY_W    = SLOT_W + DELAY_W;
  localparam int RAM_DEPTH  = 2 * TIMELINE_DEPTH;

  // input kind codes
  localparam logic KIND_REG  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic                kind;
    logic [PERIOD_W-1:0] period_ms;
    logic [PRIO_W-1:0]   priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  task_slot;
    logic [DELAY_W-1:0] next_delay_us;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LCM_LOAD,
    S_LCM_RUN,
    S_LVL,
    S_WALK,
    S_LAST,
    S_TICK_RD,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic res_invalid;
    logic res_empty;
    logic reg_start;
    logic lcm_load;
    logic lcm_run;
    logic lvl_init;
    logic walk_step;
    logic walk_fail;
    logic last_commit;
    logic tick_take;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic bad_req;
    logic empty;
    logic lcm_done;
    logic lcm_match;
    logic walk_end;
    logic walk_full;
    logic out_free;
  } sts_t;

endpackage

[rtl/ptd_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module ptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ptd_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_ctrl
// sequencer for decode, lcm search, timeline walk, commit and tick read
// ---------------------------------------------------------------------------
module ptd_ctrl
  import ptd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.is_tick) begin
          if (sts.empty) begin
            cmd.res_empty = 1'b1;
            state_nxt     = S_RESP;
          end else begin
            state_nxt = S_TICK_RD;
          end
        end else if (sts.bad_req) begin
          cmd.res_invalid = 1'b1;
          state_nxt       = S_RESP;
        end else begin
          cmd.reg_start = 1'b1;
          state_nxt     = S_LCM_LOAD;
        end
      end
      S_LCM_LOAD: begin
        if (sts.lcm_done) begin
          state_nxt = S_LVL;
        end else begin
          cmd.lcm_load = 1'b1;
          state_nxt    = S_LCM_RUN;
        end
      end
      S_LCM_RUN: begin
        cmd.lcm_run = 1'b1;
        if (sts.lcm_match) begin
          state_nxt = S_LCM_LOAD;
        end
      end
      S_LVL: begin
        cmd.lvl_init = 1'b1;
        state_nxt    = S_WALK;
      end
      S_WALK: begin
        priority if (sts.walk_end) begin
          state_nxt = S_LAST;
        end else if (sts.walk_full) begin
          cmd.walk_fail = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_LAST: begin
        cmd.last_commit = 1'b1;
        state_nxt       = S_RESP;
      end
      S_TICK_RD: begin
        cmd.tick_take = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/ptd_dpath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_dpath
// task table, lcm search, per-level due times, timeline ram and result regs
// ---------------------------------------------------------------------------
module ptd_dpath
  import ptd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [SPACING_W-1:0] cfg_wdata,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam logic [SPAN_W-1:0] SPAN_SAT = SPAN_W'(SPAN_LIMIT + 1);

  in_item_t               item_r;
  logic [SPACING_W-1:0]   spacing_r;
  logic [PERIOD_W-1:0]    reg_period_r [MAX_TASKS];
  logic [LVL_W-1:0]       reg_prio_r   [MAX_TASKS];
  logic [TASK_CNT_W-1:0]  reg_count_r;
  logic [CNT_W-1:0]       entry_count_r;
  logic [IDX_W-1:0]       pos_r;
  logic                   bank_r;

  logic [SPAN_W-1:0]      span_r, m1_r, m2_r;
  logic [TASK_CNT_W-1:0]  lcm_idx_r;

  logic                   lvl_on_r   [NUM_LEVELS];
  logic [SLOT_W-1:0]      lvl_slot_r [NUM_LEVELS];
  logic [TIME_W-1:0]      lvl_step_r [NUM_LEVELS];
  logic [TIME_W-1:0]      due_r      [NUM_LEVELS];
  logic [TIME_W-1:0]      span_us_r;

  logic [CNT_W-1:0]       count_r;
  logic [TIME_W-1:0]      prev_t_r, first_t_r;
  logic [SLOT_W-1:0]      prev_slot_r;

  out_item_t              res_r, out_data_r;
  logic                   out_valid_r;

  logic [TIDX_W-1:0]      n_idx, lcm_tidx;
  logic [TASK_CNT_W-1:0]  tot;
  logic [SPAN_W-1:0]      lcm_per;
  logic                   lvl_hit  [NUM_LEVELS];
  logic [TIDX_W-1:0]      lvl_pick [NUM_LEVELS];
  logic                   best_hit;
  logic [TIME_W-1:0]      best_t;
  logic [LVL_W-1:0]       best_lvl;
  logic [CNT_W-1:0]       count_m1, pos_inc;
  logic [TIME_W-1:0]      last_gap;
  logic                   ram_we;
  logic [IDX_W:0]         ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;

  // slot indexes
  assign n_idx    = reg_count_r[TIDX_W-1:0];
  assign lcm_tidx = lcm_idx_r[TIDX_W-1:0];
  assign tot      = reg_count_r + 1'b1;
  assign lcm_per  = SPAN_W'(reg_period_r[lcm_tidx]);

  // first registered task of each priority level
  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      lvl_hit[l]  = 1'b0;
      lvl_pick[l] = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (!lvl_hit[l] && (TASK_CNT_W'(i) < tot) && (reg_prio_r[i] == LVL_W'(l))) begin
          lvl_hit[l]  = 1'b1;
          lvl_pick[l] = TIDX_W'(i);
        end
      end
    end
  end

  // earliest due firing, lowest level wins a tie
  always_comb begin
    best_hit = 1'b0;
    best_t   = '0;
    best_lvl = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (lvl_on_r[l] && (!best_hit || (due_r[l] < best_t))) begin
        best_hit = 1'b1;
        best_t   = due_r[l];
        best_lvl = LVL_W'(l);
      end
    end
  end

  assign count_m1 = count_r - 1'b1;
  assign pos_inc  = CNT_W'(pos_r) + 1'b1;
  assign last_gap = span_us_r - prev_t_r + first_t_r;

  // status to controller
  always_comb begin
    sts.is_tick   = (item_r.kind == KIND_TICK);
    sts.bad_req   = (item_r.priority_req > PRIO_W'(PRIO_MAX)) ||
                    (item_r.period_ms == '0) ||
                    (reg_count_r >= TASK_CNT_W'(MAX_TASKS));
    sts.empty     = (entry_count_r == '0);
    sts.lcm_done  = (lcm_idx_r == tot);
    sts.lcm_match = (m1_r == m2_r) || (m1_r > SPAN_W'(SPAN_LIMIT)) ||
                    (m2_r > SPAN_W'(SPAN_LIMIT));
    sts.walk_end  = (best_t >= span_us_r);
    sts.walk_full = (count_r == CNT_W'(TIMELINE_DEPTH));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_W'(SPACING_RESET);
    end else if (cfg_we) begin
      spacing_r <= cfg_wdata;
    end
  end

  // captured transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // task table and committed timeline state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        reg_period_r[i] <= '0;
        reg_prio_r[i]   <= '0;
      end
      reg_count_r   <= '0;
      entry_count_r <= '0;
      pos_r         <= '0;
      bank_r        <= 1'b0;
    end else begin
      priority if (cmd.reg_start) begin
        reg_period_r[n_idx] <= item_r.period_ms;
        reg_prio_r[n_idx]   <= item_r.priority_req[LVL_W-1:0];
      end else if (cmd.walk_fail) begin
        reg_period_r[n_idx] <= '0;
        reg_prio_r[n_idx]   <= '0;
      end else if (cmd.last_commit) begin
        reg_count_r   <= tot;
        entry_count_r <= count_r;
        pos_r         <= '0;
        bank_r        <= ~bank_r;
      end else if (cmd.tick_take) begin
        pos_r <= (pos_inc == entry_count_r) ? '0 : pos_inc[IDX_W-1:0];
      end
    end
  end

  // lcm search by stepping the smaller multiple
  always_ff @(posedge clk) begin
    priority if (cmd.reg_start) begin
      span_r    <= (reg_count_r == '0) ? SPAN_W'(item_r.period_ms)
                                       : SPAN_W'(reg_period_r[0]);
      lcm_idx_r <= TASK_CNT_W'(1);
    end else if (cmd.lcm_load) begin
      m1_r <= span_r;
      m2_r <= lcm_per;
    end else if (cmd.lcm_run) begin
      if (sts.lcm_match) begin
        span_r    <= ((m1_r == m2_r) && (m1_r <= SPAN_W'(SPAN_LIMIT))) ? m1_r : SPAN_SAT;
        lcm_idx_r <= lcm_idx_r + 1'b1;
      end else if (m1_r < m2_r) begin
        m1_r <= m1_r + span_r;
      end else begin
        m2_r <= m2_r + lcm_per;
      end
    end
  end

  // per-level setup and timeline walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.lvl_init) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        lvl_on_r[l]   <= lvl_hit[l];
        lvl_slot_r[l] <= SLOT_W'(lvl_pick[l]);
        lvl_step_r[l] <= TIME_W'(reg_period_r[lvl_pick[l]]) * TIME_W'(US_PER_MS);
        due_r[l]      <= TIME_W'(l) * TIME_W'(spacing_r);
      end
      span_us_r <= TIME_W'(span_r) * TIME_W'(US_PER_MS);
      count_r   <= '0;
    end else if (cmd.walk_step) begin
      if (count_r == '0) begin
        first_t_r <= best_t;
      end
      prev_t_r         <= best_t;
      prev_slot_r      <= lvl_slot_r[best_lvl];
      count_r          <= count_r + 1'b1;
      due_r[best_lvl]  <= due_r[best_lvl] + lvl_step_r[best_lvl];
    end
  end

  // timeline ram: build into the idle bank, read the live bank
  always_comb begin
    ram_we    = (cmd.walk_step && (count_r != '0)) || cmd.last_commit;
    ram_waddr = {~bank_r, count_m1[IDX_W-1:0]};
    if (cmd.last_commit) begin
      ram_wdata = {prev_slot_r, last_gap[DELAY_W-1:0]};
    end else begin
      ram_wdata = {prev_slot_r, DELAY_W'(best_t - prev_t_r)};
    end
    ram_raddr = {bank_r, pos_r};
  end

  ptd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    priority if (cmd.res_invalid) begin
      res_r <= '{status: STATUS_INVALID, task_slot: '0, next_delay_us: '0};
    end else if (cmd.res_empty) begin
      res_r <= '{status: STATUS_EMPTY, task_slot: '0, next_delay_us: '0};
    end else if (cmd.walk_fail) begin
      res_r <= '{status: STATUS_OVERFLOW, task_slot: '0, next_delay_us: '0};
    end else if (cmd.last_commit) begin
      res_r <= '{status: STATUS_OK, task_slot: SLOT_W'(n_idx), next_delay_us: '0};
    end else if (cmd.tick_take) begin
      res_r <= '{status: STATUS_OK, task_slot: ram_rdata[ENTRY_W-1:DELAY_W],
                 next_delay_us: ram_rdata[DELAY_W-1:0]};
    end
  end

  // output transaction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // read pointer stays inside the live timeline
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) || (CNT_W'(pos_r) < entry_count_r))
    else $error("timeline position beyond entry count");

  // the walk never builds more entries than the ram bank holds
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TIMELINE_DEPTH))
    else $error("timeline build count above depth");

  // a commit always leaves a non-empty timeline
  a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last_commit |=> (entry_count_r != '0))
    else $error("commit produced an empty timeline");

  // a pushed result never overwrites one still waiting
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || !out_stall))
    else $error("result pushed over a stalled transaction");

endmodule

[rtl/periodic_task_timeline_dispatcher_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_task_timeline_dispatcher_unit
// cyclic executive timeline builder and tick dispatcher
// ---------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_stall  | in_item_t: kind, period_ms, priority_req
//  out_     | output    | out_valid/out_stall| out_item_t: status, task_slot, next_delay_us
//  cfg_     | input     | cfg_we             | spacing_us in cfg_wdata
//
//  a tick result passes the decode, ram read and response states before it is valid;
//  the next transaction is taken only after the result is pushed and the sequencer is idle
//  a registration runs decode, lcm search, level setup, a walk step per entry, commit and response;
//  the lcm unit steps one multiple per cycle, up to 2 * 32 * 1023 per task
//  one transaction is worked at a time; in_stall is high outside the idle state
//  the result sits in an output register, so a stalled out_ side holds only it
//  reset is synchronous active low and clears all tasks and the timeline
// ---------------------------------------------------------------------------
module periodic_task_timeline_dispatcher_unit
  import ptd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [SPACING_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath with timeline ram
  ptd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[tb/sv/tb_periodic_task_timeline_dispatcher_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_periodic_task_timeline_dispatcher_unit
// self-checking bench for the cyclic executive timeline dispatcher
// ---------------------------------------------------------------------------
// a timeline predictor mirrors task registration, timeline rebuild and tick
// dispatch; each accepted input transaction queues one expected result and
// each accepted output transaction is compared field by field in order.
// directed registrations cover rejects, overflow, shared priority, zero and
// near-maximum spacing, then random ticks and registrations run with random
// input gaps and receiver backpressure, with one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_periodic_task_timeline_dispatcher_unit;
  import ptd_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS = 600;

  // timeline predictor and result checker
  class timeline_scoreboard;
    int unsigned spacing;
    int unsigned task_period[MAX_TASKS];
    int unsigned task_prio[MAX_TASKS];
    int unsigned task_count;
    bit [SLOT_W-1:0] line_slot[TIMELINE_DEPTH];
    bit [DELAY_W-1:0] line_delay[TIMELINE_DEPTH];
    int unsigned line_count;
    int unsigned line_pos;
    out_item_t pending[$];
    int errors;

    function new();
      spacing = SPACING_RESET;
      task_count = 0;
      line_count = 0;
      line_pos = 0;
      errors = 0;
      foreach (task_period[i]) begin
        task_period[i] = 0;
        task_prio[i] = 0;
      end
    endfunction

    // rebuild the timeline over the lcm of the first n periods; 0 on overflow
    function bit rebuild(int unsigned n);
      longint unsigned span, a, b, r, ms, at, prev_at, first_at;
      int first_of[NUM_LEVELS];
      int unsigned cnt;
      bit [SLOT_W-1:0] ns[TIMELINE_DEPTH];
      bit [DELAY_W-1:0] nd[TIMELINE_DEPTH];
      span = task_period[0];
      cnt = 0;
      prev_at = 0;
      first_at = 0;
      for (int i = 1; i < n; i++) begin
        a = span;
        b = task_period[i];
        while (b != 0) begin
          r = a % b;
          a = b;
          b = r;
        end
        if (a == 0) a = 1;
        span = (span / a) * task_period[i];
      end
      for (int l = 0; l < NUM_LEVELS; l++) begin
        first_of[l] = -1;
        for (int i = 0; i < n; i++)
          if (first_of[l] < 0 && task_prio[i] == l) first_of[l] = i;
      end
      for (ms = 0; ms < span; ms++) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          if (first_of[l] < 0) continue;
          if (ms % task_period[first_of[l]] != 0) continue;
          if (cnt >= TIMELINE_DEPTH) return 0;
          at = ms * US_PER_MS + l * spacing;
          ns[cnt] = SLOT_W'(first_of[l]);
          if (cnt > 0) nd[cnt-1] = DELAY_W'(at - prev_at);
          else first_at = at;
          prev_at = at;
          cnt++;
        end
      end
      if (cnt > 0) nd[cnt-1] = DELAY_W'(span * US_PER_MS - prev_at + first_at);
      line_slot = ns;
      line_delay = nd;
      line_count = cnt;
      line_pos = 0;
      return 1;
    endfunction

    function void note_request(in_item_t it);
      out_item_t exp_res;
      exp_res = '0;
      if (it.kind == KIND_REG) begin
        if (it.priority_req > PRIO_MAX || it.period_ms == 0 || task_count >= MAX_TASKS) begin
          exp_res.status = STATUS_INVALID;
        end else begin
          task_period[task_count] = it.period_ms;
          task_prio[task_count] = it.priority_req;
          if (rebuild(task_count + 1)) begin
            exp_res.task_slot = SLOT_W'(task_count);
            task_count++;
          end else begin
            task_period[task_count] = 0;
            task_prio[task_count] = 0;
            exp_res.status = STATUS_OVERFLOW;
          end
        end
      end else if (line_count == 0) begin
        exp_res.status = STATUS_EMPTY;
      end else begin
        if (line_pos >= line_count) line_pos = 0;
        exp_res.task_slot = line_slot[line_pos];
        exp_res.next_delay_us = line_delay[line_pos];
        line_pos++;
        if (line_pos >= line_count) line_pos = 0;
      end
      pending.push_back(exp_res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.task_slot !== want.task_slot ||
          got.next_delay_us !== want.next_delay_us) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d slot %0d delay %0d, got %0d %0d %0d",
                   want.status, want.task_slot, want.next_delay_us,
                   got.status, got.task_slot, got.next_delay_us);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [SPACING_W-1:0] cfg_wdata;

  timeline_scoreboard sb;
  int cycles;
  bit long_hold_req;

  periodic_task_timeline_dispatcher_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run length guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_periodic_task_timeline_dispatcher_unit: errors");
      $finish;
    end
  end

  // output transaction check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver backpressure, with one long hold-off on request
  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req && hold == 0) begin
        hold = 500;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall = 1'b1;
      end else if (out_stall) begin
        out_stall = ($urandom_range(0, 3) == 0);
      end else begin
        out_stall = (idle_len() != 0);
      end
    end
  end

  task automatic send_item(input logic kind, input int unsigned period, input int unsigned prio);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data.kind = kind;
    in_data.period_ms = PERIOD_W'(period);
    in_data.priority_req = PRIO_W'(prio);
    do @(posedge clk); while (in_stall);
    sb.note_request(in_data);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_spacing(input int unsigned value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = SPACING_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    sb.spacing = value;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(KIND_TICK, $urandom_range(0, 1023), $urandom_range(0, 7));
  endtask

  initial begin
    sb = new();
    cycles = 0;
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty timeline, rejected arguments, first task, overflow
    send_ticks(2);
    send_item(KIND_REG, 5, 7);
    send_item(KIND_REG, 5, 4);
    send_item(KIND_REG, 0, 1);
    send_item(KIND_REG, 2, 3);
    send_ticks(3);
    send_item(KIND_REG, 1023, 0);
    send_ticks(2);
    drain();

    // zero spacing with a shared priority
    write_spacing(0);
    send_item(KIND_REG, 1, 3);
    send_ticks(4);
    drain();

    // near-maximum spacing, random small period
    write_spacing(250);
    send_item(KIND_REG, $urandom_range(1, 4), $urandom_range(0, 3));
    send_ticks(3);
    drain();

    // last slot with random spacing, then a full table
    write_spacing($urandom_range(0, 250));
    send_item(KIND_REG, $urandom_range(1, 8), $urandom_range(0, 3));
    send_item(KIND_REG, 1000, 0);
    send_ticks(3);
    drain();

    // random mix, mostly ticks
    write_spacing($urandom_range(0, 250));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) long_hold_req = 1'b1;
      if (i == 350) drain();
      if ($urandom_range(0, 99) < 85) send_ticks(1);
      else send_item(KIND_REG, $urandom_range(0, 1023), $urandom_range(0, 7));
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_periodic_task_timeline_dispatcher_unit: clean");
    else
      $display("tb_periodic_task_timeline_dispatcher_unit: errors");
    $finish;
  end

endmodule

[periodic_task_timeline_dispatcher_unit.f]
rtl/ptd_pkg.sv
rtl/ptd_ram.sv
rtl/ptd_ctrl.sv
rtl/ptd_dpath.sv
rtl/periodic_task_timeline_dispatcher_unit.sv
tb/sv/tb_periodic_task_timeline_dispatcher_unit.sv
